// File: hw/rtl/aescbc_pkg.sv
// Shared constants, types and AES round functions for the AES-256 CBC block.
`default_nettype none
package aescbc_pkg;

  localparam int NumRounds = 14;
  localparam int DecBase   = NumRounds + 1;
  localparam int RkAddrW   = 5;
  localparam int CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IVLO = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IVHI = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DIR  = 3'd6;

  localparam logic [7:0] PAD_BYTE = 8'h10;
  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef struct packed {
    logic         we;
    logic [3:0]   idx;
    logic [127:0] data;
    logic         done;
  } kx_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[7:0]; a1 = c[15:8]; a2 = c[23:16]; a3 = c[31:24];
    return {xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2,
            xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1,
            xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0,
            xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    for (int k = 0; k < 4; k++) begin
      a[k]   = c[8*k +: 8];
      x2[k]  = xtime(a[k]);
      x4[k]  = xtime(x2[k]);
      x8[k]  = xtime(x4[k]);
      m9[k]  = x8[k] ^ a[k];
      m11[k] = x8[k] ^ x2[k] ^ a[k];
      m13[k] = x8[k] ^ x4[k] ^ a[k];
      m14[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {m11[0] ^ m13[1] ^ m9[2] ^ m14[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m14[0] ^ m11[1] ^ m13[2] ^ m9[3]};
  endfunction

  function automatic logic [127:0] inv_mix_block(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) r[32*c +: 32] = inv_mix_col(s[32*c +: 32]);
    return r;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic fin);
    logic [127:0] t;
    logic [1:0]   sc;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        sc = 2'(c + row);
        t[8*(4*c+row) +: 8] = SBOX[s[8*(4*sc+row) +: 8]];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_col(t[32*c +: 32]);
    end
    return t;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic fin);
    logic [127:0] t;
    logic [1:0]   sc;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        sc = 2'(c + row);
        t[8*(4*sc+row) +: 8] = INV_SBOX[s[8*(4*c+row) +: 8]];
      end
    end
    if (!fin) t = inv_mix_block(t);
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aescbc_keyexp.sv
// AES-256 key expansion: streams the 15 encryption round keys, one per cycle.
`default_nettype none
module aescbc_keyexp
  import aescbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [255:0] key,
  output kx_wr_t            wr
);

  logic         busy;
  logic [3:0]   cnt;
  logic [255:0] win;
  logic [7:0]   rcon;
  logic [31:0]  prev, f, n0, n1, n2, n3;
  logic [31:0]  rot;

  always_comb begin
    prev = win[255:224];
    rot  = {prev[7:0], prev[31:8]};
    if (!cnt[0]) begin
      f = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]] ^ rcon};
    end else begin
      f = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
    end
    n0 = win[31:0] ^ f;
    n1 = win[63:32] ^ n0;
    n2 = win[95:64] ^ n1;
    n3 = win[127:96] ^ n2;
    wr.we  = busy;
    wr.idx = cnt;
    case (cnt)
      4'd0:    wr.data = win[127:0];
      4'd1:    wr.data = win[255:128];
      default: wr.data = {n3, n2, n1, n0};
    endcase
    wr.done = busy && (cnt == 4'(NumRounds));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      win  <= key;
      rcon <= RCON_INIT;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'(NumRounds)) busy <= 1'b0;
      if (cnt >= 4'd2) begin
        win <= {n3, n2, n1, n0, win[255:128]};
        if (!cnt[0]) rcon <= xtime(rcon);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aescbc_core.sv
// CBC engine: round key memory, key inversion sweep, round loop and result register.
`default_nettype none
module aescbc_core
  import aescbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [255:0] key,
  input  wire logic [127:0] iv,
  input  wire logic         dir,
  input  wire logic         key_wr,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [127:0] in_blk,
  input  wire logic [4:0]   in_cnt,
  input  wire logic         in_last,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [127:0]      out_blk,
  output logic [4:0]        out_bytes,
  output logic              out_last,
  output logic              out_status
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEXP, ST_DERIVE, ST_LOAD, ST_ROUND, ST_OUT
  } state_t;

  state_t       state;
  logic [127:0] rk_mem [32];
  logic [127:0] rdata;
  logic [RkAddrW-1:0] rd_addr, wr_addr, base;
  logic [127:0] wr_data;
  logic         wr_en;
  logic [127:0] blk, st, chain, padded, st_next, res;
  logic         last_q, two_q, in_msg, kx_start, bad;
  logic [1:0]   rdy;
  logic [3:0]   rnd, dcnt;
  logic [7:0]   b15;
  logic [4:0]   dec_bytes;
  kx_wr_t       kx;

  aescbc_keyexp u_keyexp (
    .clk   (clk),
    .rst   (rst),
    .start (kx_start),
    .key   (key),
    .wr    (kx)
  );

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign base     = dir ? RkAddrW'(DecBase) : '0;

  always_comb begin
    bad = dir ? (in_cnt != 5'd16) : (in_last ? (in_cnt > 5'd16) : (in_cnt != 5'd16));
    for (int i = 0; i < 16; i++) begin
      if (in_cnt >= 5'd16 || 5'(i) < in_cnt) padded[8*i +: 8] = in_blk[8*i +: 8];
      else if (i == 15) padded[8*i +: 8] = 8'(5'd16 - in_cnt);
      else padded[8*i +: 8] = PAD_BYTE;
    end
  end

  always_comb begin
    case (state)
      ST_DERIVE: rd_addr = RkAddrW'(4'(NumRounds) - dcnt);
      ST_LOAD:   rd_addr = base;
      ST_ROUND:  rd_addr = base + RkAddrW'(rnd) + RkAddrW'(1);
      default:   rd_addr = base;
    endcase
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = kx.data;
    if (state == ST_KEXP) begin
      wr_en   = kx.we;
      wr_addr = RkAddrW'(kx.idx);
    end else if (state == ST_DERIVE && dcnt != 4'd0) begin
      wr_en   = 1'b1;
      wr_addr = RkAddrW'(NumRounds) + RkAddrW'(dcnt);
      wr_data = (dcnt == 4'd1 || dcnt == 4'(NumRounds + 1)) ? rdata : inv_mix_block(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rdata <= rk_mem[rd_addr];
  end

  always_comb begin
    if (rnd == 4'd0) st_next = (dir ? blk : blk ^ chain) ^ rdata;
    else if (dir) st_next = dec_round(st, rnd == 4'(NumRounds)) ^ rdata;
    else st_next = enc_round(st, rnd == 4'(NumRounds)) ^ rdata;
    res = dir ? st ^ chain : st;
    b15 = res[127:120];
    dec_bytes = (last_q && b15 != 8'd0 && b15 <= 8'd16) ? 5'(8'd16 - b15) : 5'd16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rdy       <= '0;
      in_msg    <= 1'b0;
      chain     <= '0;
      out_valid <= 1'b0;
      kx_start  <= 1'b0;
      rnd       <= '0;
      dcnt      <= '0;
    end else begin
      kx_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (key_wr) rdy <= '0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_msg <= !in_last;
            if (!in_msg) chain <= iv;
            blk    <= padded;
            last_q <= in_last;
            two_q  <= !dir && in_last && (in_cnt == 5'd16);
            if (bad) begin
              out_valid  <= 1'b1;
              out_blk    <= '0;
              out_bytes  <= '0;
              out_last   <= in_last;
              out_status <= 1'b1;
            end else if (!rdy[0]) begin
              kx_start <= 1'b1;
              state    <= ST_KEXP;
            end else if (dir && !rdy[1]) begin
              dcnt  <= '0;
              state <= ST_DERIVE;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_KEXP: begin
          if (kx.done) begin
            rdy[0] <= 1'b1;
            dcnt   <= '0;
            state  <= (dir && !rdy[1]) ? ST_DERIVE : ST_LOAD;
          end
        end
        ST_DERIVE: begin
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(NumRounds + 1)) begin
            rdy[1] <= 1'b1;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          st  <= st_next;
          rnd <= rnd + 4'd1;
          if (rnd == 4'(NumRounds)) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            out_blk    <= res;
            out_status <= 1'b0;
            out_last   <= last_q && !two_q;
            out_bytes  <= dir ? dec_bytes : 5'd16;
            chain      <= dir ? blk : st;
            if (two_q) begin
              blk   <= {16{PAD_BYTE}};
              two_q <= 1'b0;
              state <= ST_LOAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aes256_cbc_cipher_top.sv
// Top level of the AES-256 CBC block: configuration registers and stream ports.
//
// channel   direction  signals                          contents
// s_*       in         s_tvalid/s_tready/s_tdata/tlast  input blocks
// m_*       out        m_tvalid/m_tready/m_tdata/tlast  result blocks, tuser = status
// cfg_*     in         cfg_valid/cfg_ready/index/data   register writes
//
// A block passes through load, whitening, 14 rounds and result in the one-round loop,
// which reads round keys from a memory with one read port. The first block after a key
// write adds the key expansion, and for decryption the key inversion sweep as well.
// A full final block on encryption adds a second pad block.
// Reset is synchronous; a stalled result holds the engine before the next result.
`default_nettype none
module aes256_cbc_cipher_top
  import aescbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [135:0]       s_tdata,   // block_low, block_high, byte_count, zero fill
  input  wire logic               s_tlast,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [135:0]            m_tdata,   // out_low, out_high, out_bytes, zero fill
  output logic                    m_tlast,
  output logic                    m_tuser,   // status
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [255:0] key;
  logic [127:0] iv;
  logic         dir, key_wr, wr;
  logic [127:0] out_blk;
  logic [4:0]   out_bytes;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign key_wr    = wr && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                            cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      iv  <= '0;
      dir <= 1'b0;
    end else if (wr) begin
      case (cfg_index)
        REG_KEY0: key[63:0]    <= cfg_data;
        REG_KEY1: key[127:64]  <= cfg_data;
        REG_KEY2: key[191:128] <= cfg_data;
        REG_KEY3: key[255:192] <= cfg_data;
        REG_IVLO: iv[63:0]     <= cfg_data;
        REG_IVHI: iv[127:64]   <= cfg_data;
        REG_DIR:  dir          <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  aescbc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .iv         (iv),
    .dir        (dir),
    .key_wr     (key_wr),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_blk     (s_tdata[127:0]),
    .in_cnt     (s_tdata[132:128]),
    .in_last    (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_blk    (out_blk),
    .out_bytes  (out_bytes),
    .out_last   (m_tlast),
    .out_status (m_tuser)
  );

  assign m_tdata = {3'b000, out_bytes, out_blk};

endmodule
`default_nettype wire

// File: hw/rtl/aescbc_checker.sv
// Port-level checks for the AES-256 CBC block, bound to the top level.
`default_nettype none
module aescbc_port_checks (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata,
  input wire logic         m_tlast,
  input wire logic         m_tuser
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result carries data");

  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && !m_tlast |-> m_tdata[132:128] == 5'd16)
    else $error("non-final result not full");

  a_bytes_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[132:128] <= 5'd16 && m_tdata[135:133] == 3'b000)
    else $error("byte count out of range");

endmodule

bind aes256_cbc_cipher_top aescbc_port_checks u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// File: tb/sv/aescbc_checker.sv
// Checker for the AES-256 CBC block: tracks config, predicts results, compares transfers.
module aescbc_checker
  import aescbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [135:0]       s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [135:0]       m_tdata,
  input  logic               m_tlast,
  input  logic               m_tuser,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 blocks_in,
  output int                 blocks_out
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [127:0] blk;
    logic [4:0]   nbytes;
    logic         lst;
    logic         st;
  } cbc_result_t;

  cbc_result_t  result_q[$];
  logic [255:0] key;
  logic [127:0] iv;
  logic [127:0] chain;
  logic         decrypt;
  logic         mid_msg;
  logic [127:0] rkey [15];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9 : 8'd1;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      r[32*c +: 8]    = gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3);
      r[32*c+8 +: 8]  = gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2);
      r[32*c+16 +: 8] = gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1);
      r[32*c+24 +: 8] = gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0);
    end
    return r;
  endfunction

  function automatic void expand_key();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key[32*i +: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {SBOX[t[7:0]], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]] ^ rc};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) rkey[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
  endfunction

  function automatic logic [127:0] encipher(input logic [127:0] s);
    logic [127:0] t;
    s ^= rkey[0];
    for (int r = 1; r < 15; r++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[8*(4*c+row) +: 8] = SBOX[s[8*(4*((c+row)%4)+row) +: 8]];
      if (r < 14) t = mix(t, 1'b0);
      s = t ^ rkey[r];
    end
    return s;
  endfunction

  function automatic logic [127:0] decipher(input logic [127:0] s);
    logic [127:0] t;
    s ^= rkey[14];
    for (int r = 13; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[8*(4*((c+row)%4)+row) +: 8] = INV_SBOX[s[8*(4*c+row) +: 8]];
      s = t ^ rkey[r];
      if (r > 0) s = mix(s, 1'b1);
    end
    return s;
  endfunction

  task automatic predict_cbc(input logic [127:0] blk, input logic [4:0] cnt, input logic lst);
    logic [127:0] b;
    logic [7:0]   pad;
    logic [4:0]   n;
    logic         bad;
    if (!mid_msg) chain = iv;
    mid_msg = !lst;
    bad = decrypt ? (cnt != 16) : (lst ? (cnt > 16) : (cnt != 16));
    if (bad) begin
      result_q.push_back('{128'h0, 5'd0, lst, 1'b1});
    end else if (decrypt) begin
      b = decipher(blk) ^ chain;
      chain = blk;
      pad = b[127:120];
      n = 16;
      if (lst && pad >= 1 && pad <= 16) n = 5'(16 - pad);
      result_q.push_back('{b, n, lst, 1'b0});
    end else begin
      b = blk;
      if (cnt < 16) begin
        for (int i = 0; i < 15; i++) if (i >= cnt) b[8*i +: 8] = PAD_BYTE;
        b[127:120] = 8'(16 - cnt);
      end
      chain = encipher(b ^ chain);
      if (lst && cnt == 16) begin
        result_q.push_back('{chain, 5'd16, 1'b0, 1'b0});
        chain = encipher({16{PAD_BYTE}} ^ chain);
      end
      result_q.push_back('{chain, 5'd16, lst, 1'b0});
    end
  endtask

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cbc_result_t w;
    if (rst) begin
      key = 0; iv = 0; decrypt = 0; mid_msg = 0; chain = 0;
      expand_key();
      result_q.delete();
      fail_count = 0; blocks_in = 0; blocks_out = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key[64*cfg_index +: 64] = cfg_data;
            expand_key();
          end
          REG_IVLO: iv[63:0] = cfg_data;
          REG_IVHI: iv[127:64] = cfg_data;
          REG_DIR:  decrypt = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        blocks_in++;
        predict_cbc(s_tdata[127:0], s_tdata[132:128], s_tlast);
      end
      if (m_tvalid && m_tready) begin
        blocks_out++;
        if (result_q.size() == 0) begin
          report("unexpected result", m_tdata[127:0], 128'h0);
        end else begin
          w = result_q.pop_front();
          if (m_tdata[127:0] !== w.blk) report("data", m_tdata[127:0], w.blk);
          if (m_tdata[132:128] !== w.nbytes) report("byte count", m_tdata[132:128], w.nbytes);
          if (m_tlast !== w.lst) report("last", m_tlast, w.lst);
          if (m_tuser !== w.st) report("status", m_tuser, w.st);
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

// File: tb/sv/tb_aes256_cbc_cipher_top.sv
// Testbench top for the AES-256 CBC block: stimulus, receiver stalls and verdict.
module tb_aes256_cbc_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aescbc_pkg::*;

  localparam int IdleLimit = 4000;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [135:0]       s_tdata = 0;
  logic               s_tlast = 0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [135:0]       m_tdata;
  logic               m_tlast;
  logic               m_tuser;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_KEY0;
  logic [63:0]        cfg_data = 0;

  int fail_count, pending, blocks_in, blocks_out;
  int sent = 0;
  int settings = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_req = 0;
  bit stall_done = 0;
  bit calm = 0;
  bit capture = 0;
  logic [128:0] cipher_q[$];

  aes256_cbc_cipher_top dut (.*);

  aescbc_checker chk (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver: random ready, short and long stalls, one forced long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (stall_req && !stall_done && stall_left == 0) begin
      stall_left <= 500;
      stall_done <= 1;
      m_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= !calm;
      if ($urandom_range(0, 999) < 4) stall_left <= $urandom_range(10, 60);
      m_tready <= calm || ($urandom_range(0, 99) < 65);
    end
  end

  always @(posedge clk) begin
    if (!rst && capture && m_tvalid && m_tready) cipher_q.push_back({m_tlast, m_tdata[127:0]});
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] d);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_block(input logic [127:0] blk, input logic [4:0] cnt, input logic lst);
    int r, g;
    s_tvalid <= 1;
    s_tdata <= {3'b0, cnt, blk};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    sent++;
    r = $urandom_range(0, 99);
    g = (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64(input int extreme_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < extreme_pct) return '0;
    if (r < 2 * extreme_pct) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] rnd_blk();
    return {rnd64(3), rnd64(3)};
  endfunction

  task automatic load_key(input int extreme_pct);
    cfg_write(REG_KEY0, rnd64(extreme_pct));
    cfg_write(REG_KEY1, rnd64(extreme_pct));
    cfg_write(REG_KEY2, rnd64(extreme_pct));
    cfg_write(REG_KEY3, rnd64(extreme_pct));
    cfg_write(REG_IVLO, rnd64(extreme_pct));
    cfg_write(REG_IVHI, rnd64(extreme_pct));
    settings++;
  endtask

  // decrypt whatever the last encrypt phase produced
  task automatic replay_ciphertext();
    logic [128:0] c;
    cfg_write(REG_DIR, 1);
    @(posedge clk);
    while (cipher_q.size() > 0) begin
      c = cipher_q.pop_front();
      send_block(c[127:0], 5'd16, c[128]);
    end
    drain();
  endtask

  function automatic logic [4:0] bad_count();
    int v;
    v = $urandom_range(0, 31);
    return (v == 16) ? 5'd17 : 5'(v);
  endfunction

  initial begin
    logic [4:0] cnt;
    int nmsg, len;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: all-zero key, then padding lengths, errors and round trip
    cfg_write(REG_KEY0, '0);
    cfg_write(REG_KEY1, '0);
    cfg_write(REG_KEY2, '0);
    cfg_write(REG_KEY3, '0);
    cfg_write(REG_IVLO, '0);
    cfg_write(REG_IVHI, '1);
    cfg_write(REG_DIR, 0);
    settings++;
    capture = 1;
    @(posedge clk);
    send_block('1, 5'd16, 0);
    send_block('0, 5'd16, 0);
    send_block(rnd_blk(), 5'd0, 1);
    send_block('1, 5'd16, 1);
    send_block('1, 5'd1, 1);
    send_block(rnd_blk(), 5'd15, 1);
    send_block(rnd_blk(), 5'd8, 1);
    drain();
    capture = 0;
    replay_ciphertext();
    cfg_write(REG_DIR, 0);
    @(posedge clk);
    send_block('1, 5'd5, 0);
    send_block('1, 5'd31, 1);
    send_block('1, 5'd17, 1);
    drain();
    cfg_write(REG_DIR, 1);
    @(posedge clk);
    send_block('1, 5'd0, 1);
    send_block('1, 5'd31, 0);
    send_block('0, 5'd16, 1);
    drain();
    load_key(100);
    cfg_write(REG_DIR, 0);
    capture = 1;
    @(posedge clk);
    send_block(rnd_blk(), 5'd16, 1);
    drain();
    capture = 0;
    replay_ciphertext();

    // random phases: encrypt with capture, then decrypt the capture plus noise
    while (sent < 1450) begin
      load_key(8);
      cfg_write(REG_DIR, 0);
      if (sent > 600) stall_req = 1;
      capture = 1;
      @(posedge clk);
      nmsg = $urandom_range(1, 4);
      for (int m = 0; m < nmsg; m++) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          if (k < len - 1) cnt = ($urandom_range(0, 99) < 4) ? bad_count() : 5'd16;
          else if ($urandom_range(0, 99) < 4) cnt = 5'($urandom_range(17, 31));
          else cnt = 5'($urandom_range(0, 16));
          send_block(rnd_blk(), cnt, k == len - 1);
        end
      end
      drain();
      capture = 0;
      replay_ciphertext();
      if ($urandom_range(0, 3) == 0) begin
        @(posedge clk);
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          cnt = ($urandom_range(0, 99) < 10) ? bad_count() : 5'd16;
          send_block(rnd_blk(), cnt, k == len - 1);
        end
        drain();
      end
    end

    $display("Ran %0d input blocks, %0d results, %0d key/IV settings, both directions.",
             blocks_in, blocks_out, settings);
    $display("Included padding lengths 0..16, length errors and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
